[rtl/core/teups_pkg.sv]
// ============================================================================
// teups_pkg
// Shared types and codes for the two-encoder serial poll sequencer.
// ============================================================================
package teups_pkg;

  // Configuration register indexes
  localparam int unsigned CFG_IDX_W = 3;
  localparam logic [CFG_IDX_W-1:0] CFG_QUERY_COMMAND  = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_FIRST_ADDRESS  = 3'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_SECOND_ADDRESS = 3'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_INVERT_MASK    = 3'd3;
  localparam logic [CFG_IDX_W-1:0] CFG_SEND_TIMEOUT   = 3'd4;
  localparam logic [CFG_IDX_W-1:0] CFG_REPLY_TIMEOUT  = 3'd5;

  localparam int unsigned CFG_DATA_W = 17;
  localparam int unsigned TIMEOUT_W  = 17;

  // Reset values of the configuration registers
  localparam logic [7:0]           RST_QUERY_COMMAND  = 8'd8;
  localparam logic [7:0]           RST_FIRST_ADDRESS  = 8'd1;
  localparam logic [7:0]           RST_SECOND_ADDRESS = 8'd2;
  localparam logic [1:0]           RST_INVERT_MASK    = 2'd2;
  localparam logic [TIMEOUT_W-1:0] RST_SEND_TIMEOUT   = 17'd20000;
  localparam logic [TIMEOUT_W-1:0] RST_REPLY_TIMEOUT  = 17'd120000;

  // Event codes
  localparam logic [1:0] EV_NONE    = 2'd0;
  localparam logic [1:0] EV_OK      = 2'd1;
  localparam logic [1:0] EV_TIMEOUT = 2'd2;

  // Phase codes as shown on the result
  localparam logic [1:0] PHASE_IDLE  = 2'd0;
  localparam logic [1:0] PHASE_SEND  = 2'd1;
  localparam logic [1:0] PHASE_REPLY = 2'd2;

  // Internal transaction state
  typedef enum logic [2:0] {
    PH_IDLE  = 3'b001,
    PH_SEND  = 3'b010,
    PH_REPLY = 3'b100
  } phase_t;

  typedef struct packed {
    logic [7:0]           query_command;
    logic [7:0]           first_address;
    logic [7:0]           second_address;
    logic [1:0]           invert_mask;
    logic [TIMEOUT_W-1:0] send_timeout;
    logic [TIMEOUT_W-1:0] reply_timeout;
  } cfg_t;

  typedef struct packed {
    logic       action;
    logic       tx_idle;
    logic       reply_done;
    logic [7:0] reply_high;
    logic [7:0] reply_low;
  } item_t;

  typedef struct packed {
    logic               send_valid;
    logic [7:0]         send_byte;
    logic               tx_drive;
    logic               rx_drive;
    logic               arm_receive;
    logic [1:0]         event_res;
    logic               event_encoder;
    logic signed [15:0] position;
    logic [31:0]        success_total;
    logic [31:0]        error_total;
    logic [1:0]         valid_flags;
    logic [1:0]         phase;
  } res_t;

endpackage

[rtl/core/teups_cfg_regs.sv]
// ============================================================================
// teups_cfg_regs
// Configuration register file; writes to unknown indexes are dropped.
// ============================================================================
module teups_cfg_regs (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                cfg_we,
  input  logic [teups_pkg::CFG_IDX_W-1:0]     cfg_index,
  input  logic [teups_pkg::CFG_DATA_W-1:0]    cfg_data,
  output teups_pkg::cfg_t                     cfg
);

  // Load reset values, then take writes by index
  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.query_command  <= teups_pkg::RST_QUERY_COMMAND;
      cfg.first_address  <= teups_pkg::RST_FIRST_ADDRESS;
      cfg.second_address <= teups_pkg::RST_SECOND_ADDRESS;
      cfg.invert_mask    <= teups_pkg::RST_INVERT_MASK;
      cfg.send_timeout   <= teups_pkg::RST_SEND_TIMEOUT;
      cfg.reply_timeout  <= teups_pkg::RST_REPLY_TIMEOUT;
    end else if (cfg_we) begin
      case (cfg_index)
        teups_pkg::CFG_QUERY_COMMAND:  cfg.query_command  <= cfg_data[7:0];
        teups_pkg::CFG_FIRST_ADDRESS:  cfg.first_address  <= cfg_data[7:0];
        teups_pkg::CFG_SECOND_ADDRESS: cfg.second_address <= cfg_data[7:0];
        teups_pkg::CFG_INVERT_MASK:    cfg.invert_mask    <= cfg_data[1:0];
        teups_pkg::CFG_SEND_TIMEOUT:   cfg.send_timeout   <= cfg_data;
        teups_pkg::CFG_REPLY_TIMEOUT:  cfg.reply_timeout  <= cfg_data;
        default: ;
      endcase
    end
  end

endmodule

[rtl/core/teups_step.sv]
// ============================================================================
// teups_step
// Transaction state and the single-pass update for one item.
// ============================================================================
module teups_step (
  input  logic              clk,
  input  logic              rst,
  input  logic              fire,
  input  teups_pkg::item_t  item,
  input  teups_pkg::cfg_t   cfg,
  output teups_pkg::res_t   res
);

  teups_pkg::phase_t              phase_reg, phase_next;
  logic                           next_encoder, next_encoder_next;
  logic                           active_encoder, active_encoder_next;
  logic                           poll_pending, poll_pending_next;
  logic [teups_pkg::TIMEOUT_W-1:0] wait_count, wait_count_next;
  logic [teups_pkg::TIMEOUT_W-1:0] wait_dec;
  logic [15:0]                    counts [2];
  logic [15:0]                    counts_next [2];
  logic [31:0]                    successes [2];
  logic [31:0]                    successes_next [2];
  logic [31:0]                    failures [2];
  logic [31:0]                    failures_next [2];
  logic [1:0]                     valid_bits, valid_bits_next;
  logic [15:0]                    raw;
  logic                           a;
  logic                           send_valid;
  logic [7:0]                     send_byte;
  logic                           arm;
  logic [1:0]                     ev;
  logic                           timed_out;

  assign a        = active_encoder;
  assign wait_dec = (wait_count != '0) ? wait_count - teups_pkg::TIMEOUT_W'(1) : wait_count;
  assign timed_out = (wait_dec == '0);
  assign raw = cfg.invert_mask[a] ? 16'(16'd0 - {item.reply_high, item.reply_low})
                                  : {item.reply_high, item.reply_low};

  // Work out the next state and the event for this item
  always_comb begin
    phase_next          = phase_reg;
    next_encoder_next   = next_encoder;
    active_encoder_next = active_encoder;
    poll_pending_next   = poll_pending;
    wait_count_next     = wait_count;
    counts_next         = counts;
    successes_next      = successes;
    failures_next       = failures;
    valid_bits_next     = valid_bits;
    send_valid          = 1'b0;
    send_byte           = 8'd0;
    arm                 = 1'b0;
    ev                  = teups_pkg::EV_NONE;

    if (!item.action) begin
      poll_pending_next = 1'b1;
    end else begin
      case (phase_reg)
        teups_pkg::PH_IDLE: begin
          if (poll_pending) begin
            poll_pending_next   = 1'b0;
            active_encoder_next = next_encoder;
            next_encoder_next   = ~next_encoder;
            phase_next          = teups_pkg::PH_SEND;
            wait_count_next     = cfg.send_timeout;
            send_valid          = 1'b1;
            send_byte           = cfg.query_command |
                                  (next_encoder ? cfg.second_address : cfg.first_address);
          end
        end
        teups_pkg::PH_SEND: begin
          if (item.tx_idle) begin
            phase_next      = teups_pkg::PH_REPLY;
            wait_count_next = cfg.reply_timeout;
            arm             = 1'b1;
          end else begin
            wait_count_next = wait_dec;
            if (timed_out) begin
              failures_next[a] = failures[a] + 32'd1;
              valid_bits_next[a] = 1'b0;
              phase_next       = teups_pkg::PH_IDLE;
              ev               = teups_pkg::EV_TIMEOUT;
            end
          end
        end
        teups_pkg::PH_REPLY: begin
          if (item.reply_done) begin
            counts_next[a]     = raw;
            successes_next[a]  = successes[a] + 32'd1;
            valid_bits_next[a] = 1'b1;
            phase_next         = teups_pkg::PH_IDLE;
            wait_count_next    = '0;
            ev                 = teups_pkg::EV_OK;
          end else begin
            wait_count_next = wait_dec;
            if (timed_out) begin
              failures_next[a] = failures[a] + 32'd1;
              valid_bits_next[a] = 1'b0;
              phase_next       = teups_pkg::PH_IDLE;
              ev               = teups_pkg::EV_TIMEOUT;
            end
          end
        end
        default: begin
          phase_next      = teups_pkg::PH_IDLE;
          wait_count_next = '0;
        end
      endcase
    end
  end

  // Build the result from the updated state
  always_comb begin
    res.send_valid    = send_valid;
    res.send_byte     = send_byte;
    res.tx_drive      = (phase_next == teups_pkg::PH_SEND);
    res.rx_drive      = (phase_next == teups_pkg::PH_REPLY);
    res.arm_receive   = arm;
    res.event_res     = ev;
    res.event_encoder = active_encoder_next;
    res.position      = counts_next[active_encoder_next];
    res.success_total = successes_next[active_encoder_next];
    res.error_total   = failures_next[active_encoder_next];
    res.valid_flags   = valid_bits_next;
    case (phase_next)
      teups_pkg::PH_SEND:  res.phase = teups_pkg::PHASE_SEND;
      teups_pkg::PH_REPLY: res.phase = teups_pkg::PHASE_REPLY;
      default:             res.phase = teups_pkg::PHASE_IDLE;
    endcase
  end

  // Advance the state on each processed item
  always_ff @(posedge clk) begin
    if (rst) begin
      phase_reg      <= teups_pkg::PH_IDLE;
      next_encoder   <= 1'b0;
      active_encoder <= 1'b0;
      poll_pending   <= 1'b1;
      wait_count     <= '0;
      counts[0]      <= '0;
      counts[1]      <= '0;
      successes[0]   <= '0;
      successes[1]   <= '0;
      failures[0]    <= '0;
      failures[1]    <= '0;
      valid_bits     <= '0;
    end else if (fire) begin
      phase_reg      <= phase_next;
      next_encoder   <= next_encoder_next;
      active_encoder <= active_encoder_next;
      poll_pending   <= poll_pending_next;
      wait_count     <= wait_count_next;
      counts         <= counts_next;
      successes      <= successes_next;
      failures       <= failures_next;
      valid_bits     <= valid_bits_next;
    end
  end

endmodule

[rtl/core/two_encoder_uart_poll_sequencer.sv]
// ============================================================================
// two_encoder_uart_poll_sequencer
// Half-duplex poller for two position encoders on one serial line.
// ============================================================================
// Usage:
//   Input channel (in_valid / in_stall) carries one item per transaction:
//   action 0 marks a poll as due, action 1 advances the bus transaction one
//   phase using tx_idle, reply_done and the two reply bytes.
//   Output channel (out_valid / out_stall) returns exactly one result per
//   item: query byte to send, bus buffer enables, receiver arm, event code
//   with the encoder's count and wrapping success/timeout totals.
//   The config port (cfg_we, cfg_index, cfg_data) writes one register per
//   cycle; write it only while no item is in flight.
// Throughput:
//   An item is registered at acceptance and processed in the next cycle unless
//   a stalled result still holds the output register; its result is registered
//   as it is processed. One item per cycle is sustained while out_stall is low;
//   the state update is a single pass through the step logic.
// Reset:
//   rst clears both stages, loads the register defaults, puts the sequencer
//   in idle with a poll due and clears all counts, totals and valid flags.
// Stall:
//   While out_stall holds a result, the next processed item waits in the
//   input register; in_stall rises only when that register is also full.
// ============================================================================
module two_encoder_uart_poll_sequencer (
  input  logic                             clk,
  input  logic                             rst,
  // configuration
  input  logic                             cfg_we,
  input  logic [teups_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [teups_pkg::CFG_DATA_W-1:0] cfg_data,
  // input channel
  input  logic                             in_valid,
  output logic                             in_stall,
  input  logic                             action,
  input  logic                             tx_idle,
  input  logic                             reply_done,
  input  logic [7:0]                       reply_high,
  input  logic [7:0]                       reply_low,
  // output channel
  output logic                             out_valid,
  input  logic                             out_stall,
  output logic                             send_valid,
  output logic [7:0]                       send_byte,
  output logic                             tx_drive,
  output logic                             rx_drive,
  output logic                             arm_receive,
  output logic [1:0]                       event_res,
  output logic                             event_encoder,
  output logic signed [15:0]               position,
  output logic [31:0]                      success_total,
  output logic [31:0]                      error_total,
  output logic [1:0]                       valid_flags,
  output logic [1:0]                       phase
);

  teups_pkg::cfg_t  cfg;
  teups_pkg::item_t item_q;
  teups_pkg::res_t  res_d;
  teups_pkg::res_t  res_q;
  logic             in_full;
  logic             in_take;
  logic             fire;

  assign fire     = in_full && !(out_valid && out_stall);
  assign in_stall = in_full && out_valid && out_stall;
  assign in_take  = in_valid && !in_stall;

  teups_cfg_regs u_cfg (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .cfg       (cfg)
  );

  teups_step u_step (
    .clk  (clk),
    .rst  (rst),
    .fire (fire),
    .item (item_q),
    .cfg  (cfg),
    .res  (res_d)
  );

  // Input register: hold the item until the step logic takes it
  always_ff @(posedge clk) begin
    if (rst) begin
      in_full <= 1'b0;
    end else begin
      in_full <= in_take || (in_full && !fire);
    end
  end

  always_ff @(posedge clk) begin
    if (in_take) begin
      item_q.action     <= action;
      item_q.tx_idle    <= tx_idle;
      item_q.reply_done <= reply_done;
      item_q.reply_high <= reply_high;
      item_q.reply_low  <= reply_low;
    end
  end

  // Result register: hold while the receiver stalls
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else begin
      out_valid <= fire || (out_valid && out_stall);
    end
  end

  always_ff @(posedge clk) begin
    if (fire) begin
      res_q <= res_d;
    end
  end

  // Drive the result fields
  assign send_valid    = res_q.send_valid;
  assign send_byte     = res_q.send_byte;
  assign tx_drive      = res_q.tx_drive;
  assign rx_drive      = res_q.rx_drive;
  assign arm_receive   = res_q.arm_receive;
  assign event_res     = res_q.event_res;
  assign event_encoder = res_q.event_encoder;
  assign position      = res_q.position;
  assign success_total = res_q.success_total;
  assign error_total   = res_q.error_total;
  assign valid_flags   = res_q.valid_flags;
  assign phase         = res_q.phase;

endmodule

[rtl/core/teups_port_checker.sv]
// ============================================================================
// teups_port_checker
// Port-level checks of the poll sequencer, bound to the top level.
// ============================================================================
module teups_port_checker (
  input logic                             clk,
  input logic                             rst,
  input logic                             out_valid,
  input logic                             out_stall,
  input logic                             send_valid,
  input logic                             tx_drive,
  input logic                             rx_drive,
  input logic                             arm_receive,
  input logic [1:0]                       event_res,
  input logic                             event_encoder,
  input logic [1:0]                       valid_flags,
  input logic [1:0]                       phase
);

  // A stalled result stays offered
  assert property (@(posedge clk) disable iff (rst)
    out_valid && out_stall |=> out_valid)
    else $error("result dropped while stalled");

  // A query byte always opens the waiting-send phase with transmit driven
  assert property (@(posedge clk) disable iff (rst)
    out_valid && send_valid |->
      phase == teups_pkg::PHASE_SEND && tx_drive && !rx_drive && !arm_receive)
    else $error("query sent outside the send phase");

  // Arming the receiver turns the bus around
  assert property (@(posedge clk) disable iff (rst)
    out_valid && arm_receive |-> phase == teups_pkg::PHASE_REPLY && rx_drive && !tx_drive)
    else $error("receiver armed without bus turnaround");

  // Any completed transaction returns to idle with the bus released
  assert property (@(posedge clk) disable iff (rst)
    out_valid && event_res != teups_pkg::EV_NONE |->
      phase == teups_pkg::PHASE_IDLE && !tx_drive && !rx_drive)
    else $error("transaction end without return to idle");

  // Success sets and timeout clears the encoder's valid flag
  assert property (@(posedge clk) disable iff (rst)
    out_valid && event_res != teups_pkg::EV_NONE |->
      valid_flags[event_encoder] == (event_res == teups_pkg::EV_OK))
    else $error("valid flag disagrees with event");

endmodule

bind two_encoder_uart_poll_sequencer teups_port_checker u_port_checker (.*);

[test/testbench.sv]
`timescale 1ns / 100ps
// ============================================================================
// testbench
// Self-checking bench for the two-encoder serial poll sequencer. A scoreboard
// predicts one report per accepted item, tracking poll, send and reply phases,
// countdowns, counts and totals, and compares every returned report field by
// field. Directed items cover reset defaults, a zero send timeout, inverted 0x8000
// and polls in every phase. Random poll transactions with noise follow under
// several register settings, with random idling on both sides.
// ============================================================================
module testbench;

  localparam int          HALF_PERIOD   = 4;
  localparam int          HOLD_CYCLES   = 300;
  localparam int unsigned CYCLE_LIMIT   = 500000;
  localparam int          PHASE_ITEMS   = 105;
  localparam int          RANDOM_PHASES = 8;
  localparam int          MAX_SHOWN     = 10;

  // --------------------------------------------------------------------------
  // Predict the report of every accepted transaction and check returned ones
  // --------------------------------------------------------------------------
  class encoder_poll_scoreboard;
    teups_pkg::cfg_t   regs;
    teups_pkg::phase_t ph;
    logic              next_enc;
    logic              act_enc;
    logic              poll_due;
    logic [16:0]       countdown;
    logic [15:0]       count_val [2];
    logic [31:0]       ok_total [2];
    logic [31:0]       err_total [2];
    logic [1:0]        valid_bits;
    teups_pkg::res_t   expected_reports [$];
    int                errors;

    function new();
      regs.query_command  = teups_pkg::RST_QUERY_COMMAND;
      regs.first_address  = teups_pkg::RST_FIRST_ADDRESS;
      regs.second_address = teups_pkg::RST_SECOND_ADDRESS;
      regs.invert_mask    = teups_pkg::RST_INVERT_MASK;
      regs.send_timeout   = teups_pkg::RST_SEND_TIMEOUT;
      regs.reply_timeout  = teups_pkg::RST_REPLY_TIMEOUT;
      ph         = teups_pkg::PH_IDLE;
      next_enc   = 1'b0;
      act_enc    = 1'b0;
      poll_due   = 1'b1;
      countdown  = '0;
      valid_bits = '0;
      errors     = 0;
      for (int i = 0; i < 2; i++) begin
        count_val[i] = '0;
        ok_total[i]  = '0;
        err_total[i] = '0;
      end
    endfunction

    function void set_reg(logic [teups_pkg::CFG_IDX_W-1:0] idx,
                          logic [teups_pkg::CFG_DATA_W-1:0] val);
      case (idx)
        teups_pkg::CFG_QUERY_COMMAND:  regs.query_command  = val[7:0];
        teups_pkg::CFG_FIRST_ADDRESS:  regs.first_address  = val[7:0];
        teups_pkg::CFG_SECOND_ADDRESS: regs.second_address = val[7:0];
        teups_pkg::CFG_INVERT_MASK:    regs.invert_mask    = val[1:0];
        teups_pkg::CFG_SEND_TIMEOUT:   regs.send_timeout   = val;
        teups_pkg::CFG_REPLY_TIMEOUT:  regs.reply_timeout  = val;
        default: ;
      endcase
    endfunction

    // Count down one waiting step; expire into a timeout at zero
    function logic [1:0] tick_countdown(logic e);
      if (countdown != 0) countdown = countdown - 17'd1;
      if (countdown == 0) begin
        err_total[e]  = err_total[e] + 32'd1;
        valid_bits[e] = 1'b0;
        ph            = teups_pkg::PH_IDLE;
        return teups_pkg::EV_TIMEOUT;
      end
      return teups_pkg::EV_NONE;
    endfunction

    function void note_item(teups_pkg::item_t it);
      teups_pkg::res_t r;
      logic            e;
      logic [15:0]     raw;
      r = '0;
      e = act_enc;
      r.event_res = teups_pkg::EV_NONE;
      if (!it.action) begin
        poll_due = 1'b1;
      end else begin
        case (ph)
          teups_pkg::PH_IDLE: begin
            if (poll_due) begin
              poll_due    = 1'b0;
              act_enc     = next_enc;
              e           = act_enc;
              next_enc    = ~e;
              r.send_valid = 1'b1;
              r.send_byte = regs.query_command |
                            (e ? regs.second_address : regs.first_address);
              ph          = teups_pkg::PH_SEND;
              countdown   = regs.send_timeout;
            end
          end
          teups_pkg::PH_SEND: begin
            if (it.tx_idle) begin
              ph            = teups_pkg::PH_REPLY;
              countdown     = regs.reply_timeout;
              r.arm_receive = 1'b1;
            end else begin
              r.event_res = tick_countdown(e);
            end
          end
          teups_pkg::PH_REPLY: begin
            if (it.reply_done) begin
              raw = {it.reply_high, it.reply_low};
              if (regs.invert_mask[e]) raw = -raw;
              count_val[e]  = raw;
              ok_total[e]   = ok_total[e] + 32'd1;
              valid_bits[e] = 1'b1;
              ph            = teups_pkg::PH_IDLE;
              countdown     = '0;
              r.event_res   = teups_pkg::EV_OK;
            end else begin
              r.event_res = tick_countdown(e);
            end
          end
          default: begin
            ph        = teups_pkg::PH_IDLE;
            countdown = '0;
          end
        endcase
      end
      r.tx_drive      = (ph == teups_pkg::PH_SEND);
      r.rx_drive      = (ph == teups_pkg::PH_REPLY);
      r.event_encoder = e;
      r.position      = count_val[e];
      r.success_total = ok_total[e];
      r.error_total   = err_total[e];
      r.valid_flags   = valid_bits;
      r.phase         = (ph == teups_pkg::PH_SEND)  ? teups_pkg::PHASE_SEND :
                        (ph == teups_pkg::PH_REPLY) ? teups_pkg::PHASE_REPLY :
                                                      teups_pkg::PHASE_IDLE;
      expected_reports.push_back(r);
    endfunction

    function void note_failure(string msg);
      errors++;
      if (errors <= MAX_SHOWN) $display("[%0t] MISMATCH %s", $time, msg);
    endfunction

    function void cmp(string field, logic [31:0] want, logic [31:0] got);
      if (got !== want)
        note_failure($sformatf("%s: expected %h, got %h", field, want, got));
    endfunction

    function void check_report(teups_pkg::res_t got);
      teups_pkg::res_t want;
      if (expected_reports.size() == 0) begin
        note_failure("report with no transaction outstanding");
        return;
      end
      want = expected_reports.pop_front();
      cmp("send_valid",    want.send_valid,    got.send_valid);
      cmp("send_byte",     want.send_byte,     got.send_byte);
      cmp("tx_drive",      want.tx_drive,      got.tx_drive);
      cmp("rx_drive",      want.rx_drive,      got.rx_drive);
      cmp("arm_receive",   want.arm_receive,   got.arm_receive);
      cmp("event_res",     want.event_res,     got.event_res);
      cmp("event_encoder", want.event_encoder, got.event_encoder);
      cmp("position",      want.position,      got.position);
      cmp("success_total", want.success_total, got.success_total);
      cmp("error_total",   want.error_total,   got.error_total);
      cmp("valid_flags",   want.valid_flags,   got.valid_flags);
      cmp("phase",         want.phase,         got.phase);
    endfunction
  endclass

  // --------------------------------------------------------------------------
  // Signals and block instance
  // --------------------------------------------------------------------------
  logic                             clk = 1'b0;
  logic                             rst;
  logic                             cfg_we;
  logic [teups_pkg::CFG_IDX_W-1:0]  cfg_index;
  logic [teups_pkg::CFG_DATA_W-1:0] cfg_data;
  logic                             in_valid;
  logic                             in_stall;
  logic                             action;
  logic                             tx_idle;
  logic                             reply_done;
  logic [7:0]                       reply_high;
  logic [7:0]                       reply_low;
  logic                             out_valid;
  logic                             out_stall;
  logic                             send_valid;
  logic [7:0]                       send_byte;
  logic                             tx_drive;
  logic                             rx_drive;
  logic                             arm_receive;
  logic [1:0]                       event_res;
  logic                             event_encoder;
  logic signed [15:0]               position;
  logic [31:0]                      success_total;
  logic [31:0]                      error_total;
  logic [1:0]                       valid_flags;
  logic [1:0]                       phase;

  encoder_poll_scoreboard sb;
  teups_pkg::res_t seen;
  bit          quiet    = 1'b0;
  bit          hold_req = 1'b0;
  int          sent_items = 0;
  int unsigned cycle_count = 0;

  two_encoder_uart_poll_sequencer u_top (
    .clk(clk), .rst(rst),
    .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data),
    .in_valid(in_valid), .in_stall(in_stall),
    .action(action), .tx_idle(tx_idle), .reply_done(reply_done),
    .reply_high(reply_high), .reply_low(reply_low),
    .out_valid(out_valid), .out_stall(out_stall),
    .send_valid(send_valid), .send_byte(send_byte),
    .tx_drive(tx_drive), .rx_drive(rx_drive), .arm_receive(arm_receive),
    .event_res(event_res), .event_encoder(event_encoder), .position(position),
    .success_total(success_total), .error_total(error_total),
    .valid_flags(valid_flags), .phase(phase)
  );

  always #HALF_PERIOD clk = ~clk;

  always @(posedge clk) cycle_count <= cycle_count + 1;

  // Mostly short gaps, now and then a long one
  function automatic int idle_len();
    if ($urandom_range(0, 99) < 85) return $urandom_range(1, 3);
    return $urandom_range(10, 40);
  endfunction

  function automatic teups_pkg::item_t mk(logic act, logic tx, logic done,
                                          logic [7:0] hi, logic [7:0] lo);
    teups_pkg::item_t it;
    it.action     = act;
    it.tx_idle    = tx;
    it.reply_done = done;
    it.reply_high = hi;
    it.reply_low  = lo;
    return it;
  endfunction

  function automatic logic rbit();
    return 1'($urandom_range(0, 1));
  endfunction

  function automatic logic [7:0] rbyte();
    return 8'($urandom_range(0, 255));
  endfunction

  function automatic logic [teups_pkg::CFG_DATA_W-1:0] rval(int unsigned hi);
    return teups_pkg::CFG_DATA_W'($urandom_range(0, hi));
  endfunction

  // --------------------------------------------------------------------------
  // Sender: offer one transaction, hold it until accepted (entered at negedge)
  // --------------------------------------------------------------------------
  task automatic send_item(teups_pkg::item_t it);
    int gap;
    gap = (!quiet && $urandom_range(0, 99) < 30) ? idle_len() : 0;
    if (gap > 0) begin
      in_valid = 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_valid   = 1'b1;
    action     = it.action;
    tx_idle    = it.tx_idle;
    reply_done = it.reply_done;
    reply_high = it.reply_high;
    reply_low  = it.reply_low;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    sb.note_item(it);
    sent_items++;
    @(negedge clk);
  endtask

  // Stop offering and wait until every report is back
  task automatic drain();
    in_valid = 1'b0;
    while (sb.expected_reports.size() != 0) @(negedge clk);
    repeat (4) @(negedge clk);
  endtask

  task automatic write_reg(logic [teups_pkg::CFG_IDX_W-1:0] idx,
                           logic [teups_pkg::CFG_DATA_W-1:0] val);
    cfg_we    = 1'b1;
    cfg_index = idx;
    cfg_data  = val;
    @(negedge clk);
    cfg_we = 1'b0;
    sb.set_reg(idx, val);
  endtask

  // One poll transaction with random waits; most polls are announced first
  task automatic poll_transaction();
    int waits;
    if ($urandom_range(0, 3) != 0)
      send_item(mk(1'b0, rbit(), rbit(), rbyte(), rbyte()));
    send_item(mk(1'b1, rbit(), rbit(), rbyte(), rbyte()));
    waits = $urandom_range(0, 4);
    repeat (waits) send_item(mk(1'b1, 1'b0, rbit(), rbyte(), rbyte()));
    send_item(mk(1'b1, 1'b1, rbit(), rbyte(), rbyte()));
    waits = $urandom_range(0, 5);
    repeat (waits) send_item(mk(1'b1, rbit(), 1'b0, rbyte(), rbyte()));
    send_item(mk(1'b1, rbit(), 1'b1, rbyte(), rbyte()));
  endtask

  // --------------------------------------------------------------------------
  // Receiver: random stalls, plus one long hold-off on request
  // --------------------------------------------------------------------------
  initial begin : receiver
    int n;
    out_stall = 1'b0;
    forever begin
      @(negedge clk);
      if (hold_req) begin
        hold_req  = 1'b0;
        out_stall = 1'b1;
        repeat (HOLD_CYCLES) @(negedge clk);
        out_stall = 1'b0;
      end else if (!quiet && $urandom_range(0, 99) < 25) begin
        n = idle_len();
        out_stall = 1'b1;
        repeat (n) @(negedge clk);
        out_stall = 1'b0;
      end else begin
        out_stall = 1'b0;
      end
    end
  end

  // Check every accepted report
  always @(posedge clk) begin
    if (!rst && out_valid && !out_stall) begin
      seen.send_valid    = send_valid;
      seen.send_byte     = send_byte;
      seen.tx_drive      = tx_drive;
      seen.rx_drive      = rx_drive;
      seen.arm_receive   = arm_receive;
      seen.event_res     = event_res;
      seen.event_encoder = event_encoder;
      seen.position      = position;
      seen.success_total = success_total;
      seen.error_total   = error_total;
      seen.valid_flags   = valid_flags;
      seen.phase         = phase;
      sb.check_report(seen);
    end
  end

  // Abort a hung run
  initial begin : watchdog
    wait (cycle_count >= CYCLE_LIMIT);
    $display("CHECKS FAILED");
    $finish;
  end

  // --------------------------------------------------------------------------
  // Stimulus
  // --------------------------------------------------------------------------
  initial begin : stimulus
    int target;
    bit paused;
    rst        = 1'b1;
    cfg_we     = 1'b0;
    cfg_index  = '0;
    cfg_data   = '0;
    in_valid   = 1'b0;
    action     = 1'b0;
    tx_idle    = 1'b0;
    reply_done = 1'b0;
    reply_high = '0;
    reply_low  = '0;
    paused     = 1'b0;
    sb = new();
    repeat (6) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;

    // Reset defaults: poll due at start, encoder one inverted
    send_item(mk(1'b1, 1'b0, 1'b1, 8'hFF, 8'hFF));
    send_item(mk(1'b1, 1'b0, 1'b1, 8'hFF, 8'hFF));
    send_item(mk(1'b1, 1'b1, 1'b0, 8'h00, 8'h00));
    send_item(mk(1'b1, 1'b1, 1'b0, 8'hFF, 8'hFF));
    send_item(mk(1'b1, 1'b0, 1'b1, 8'h12, 8'h34));
    send_item(mk(1'b1, 1'b1, 1'b1, 8'h00, 8'h00));   // idle, no poll due
    send_item(mk(1'b0, 1'b0, 1'b0, 8'h00, 8'h00));
    send_item(mk(1'b1, 1'b0, 1'b0, 8'h00, 8'h00));
    send_item(mk(1'b1, 1'b1, 1'b0, 8'h00, 8'h00));
    send_item(mk(1'b1, 1'b1, 1'b1, 8'h00, 8'h01));
    drain();

    // Zero send countdown, one-step reply countdown, both encoders inverted
    write_reg(teups_pkg::CFG_QUERY_COMMAND, 17'h00);
    write_reg(teups_pkg::CFG_FIRST_ADDRESS, 17'hFF);
    write_reg(teups_pkg::CFG_SECOND_ADDRESS, 17'h00);
    write_reg(teups_pkg::CFG_INVERT_MASK, 17'd3);
    write_reg(teups_pkg::CFG_SEND_TIMEOUT, 17'd0);
    write_reg(teups_pkg::CFG_REPLY_TIMEOUT, 17'd1);
    send_item(mk(1'b0, 1'b1, 1'b1, 8'hFF, 8'h00));
    send_item(mk(1'b1, 1'b0, 1'b0, 8'h00, 8'h00));
    send_item(mk(1'b0, 1'b1, 1'b1, 8'hFF, 8'hFF));   // poll while sending
    send_item(mk(1'b1, 1'b0, 1'b1, 8'h00, 8'h00));   // send timeout at once
    send_item(mk(1'b1, 1'b0, 1'b0, 8'h00, 8'h00));
    send_item(mk(1'b1, 1'b1, 1'b0, 8'h00, 8'h00));
    send_item(mk(1'b0, 1'b0, 1'b0, 8'h00, 8'h00));   // poll while awaiting reply
    send_item(mk(1'b1, 1'b1, 1'b0, 8'hFF, 8'hFF));   // reply timeout
    send_item(mk(1'b1, 1'b0, 1'b0, 8'h00, 8'h00));
    send_item(mk(1'b1, 1'b1, 1'b0, 8'h00, 8'h00));
    send_item(mk(1'b1, 1'b0, 1'b1, 8'h80, 8'h00));   // negated 0x8000 stays
    send_item(mk(1'b0, 1'b0, 1'b0, 8'h00, 8'h00));
    send_item(mk(1'b1, 1'b0, 1'b0, 8'h00, 8'h00));
    send_item(mk(1'b1, 1'b1, 1'b0, 8'h00, 8'h00));
    send_item(mk(1'b1, 1'b0, 1'b1, 8'h00, 8'h00));

    // Random poll traffic under several register settings
    for (int p = 0; p < RANDOM_PHASES; p++) begin
      drain();
      write_reg(teups_pkg::CFG_QUERY_COMMAND, rval(255));
      write_reg(teups_pkg::CFG_FIRST_ADDRESS, rval(255));
      write_reg(teups_pkg::CFG_SECOND_ADDRESS, rval(255));
      write_reg(teups_pkg::CFG_INVERT_MASK, rval(3));
      case (p)
        0: begin
          write_reg(teups_pkg::CFG_SEND_TIMEOUT, 17'h1FFFF);
          write_reg(teups_pkg::CFG_REPLY_TIMEOUT, 17'h1FFFF);
        end
        1: begin
          write_reg(teups_pkg::CFG_SEND_TIMEOUT, 17'd0);
          write_reg(teups_pkg::CFG_REPLY_TIMEOUT, 17'd0);
        end
        default: begin
          write_reg(teups_pkg::CFG_SEND_TIMEOUT, rval(6));
          write_reg(teups_pkg::CFG_REPLY_TIMEOUT, rval(6));
        end
      endcase
      quiet = (p == 2 || p == 5);
      // Hold the receiver off while the sender keeps pushing
      if (p == 2) hold_req = 1'b1;
      target = sent_items + PHASE_ITEMS;
      while (sent_items < target) begin
        if (p == 4 && !paused && sent_items >= target - PHASE_ITEMS / 2) begin
          drain();
          paused = 1'b1;
        end
        if ($urandom_range(0, 99) < 15) begin
          repeat ($urandom_range(1, 4))
            send_item(mk(rbit(), rbit(), rbit(), rbyte(), rbyte()));
        end else begin
          poll_transaction();
        end
      end
    end
    quiet = 1'b0;

    drain();
    repeat (8) @(negedge clk);
    if (sb.errors == 0 && sb.expected_reports.size() == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

endmodule
